/* rtl/bending_strip_shot_integrator_unit_assert.svh */
// ----------------------------------------------------------------------------
// bending strip shot integrator assertion macros
// shared concurrent checks, reset disables them
// ----------------------------------------------------------------------------
`ifndef BENDING_STRIP_SHOT_INTEGRATOR_UNIT_ASSERT_SVH
`define BENDING_STRIP_SHOT_INTEGRATOR_UNIT_ASSERT_SVH

// consequent must hold in the same cycle
`define BSSI_ASSERT_SAME(lbl, ck, rn, ante, cons) \
lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("bssi check failed in the same cycle");

// consequent must hold in the next cycle
`define BSSI_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("bssi check failed one cycle later");

`endif

/* rtl/bssi_pkg.sv */
// ----------------------------------------------------------------------------
// bssi_pkg
// shared widths, register codes, constants and helpers of the shot integrator
// ----------------------------------------------------------------------------
package bssi_pkg;

    localparam int FRAC_BITS_DEF   = 24;
    localparam int INDEX_WIDTH_DEF = 12;

    localparam int Q_W       = 32;
    localparam int H_W       = 25;
    localparam int STEPS_W   = 12;
    localparam int ERR_W     = 31;
    localparam int XSUM_W    = 48;
    localparam int PEN_W     = 40;
    localparam int CFG_IDX_W = 3;
    localparam int CORDIC_ITERS = 30;

    // configuration register codes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_M      = 3'd0,
        REG_COEF_N      = 3'd1,
        REG_INV_TWO_M   = 3'd2,
        REG_START_ANGLE = 3'd3,
        REG_STEP_LENGTH = 3'd4,
        REG_STEPS       = 3'd5
    } cfg_reg_t;

    // reset values of the registers
    localparam logic signed [Q_W-1:0] COEF_M_RST      = 32'sd16777216;
    localparam logic signed [Q_W-1:0] COEF_N_RST      = 32'sd0;
    localparam logic signed [Q_W-1:0] INV_TWO_M_RST   = 32'sd8388608;
    localparam logic signed [Q_W-1:0] START_ANGLE_RST = 32'sd0;
    localparam logic [H_W-1:0]        STEP_LENGTH_RST = 25'd33622;
    localparam logic [STEPS_W-1:0]    STEPS_RST       = 12'd500;

    // angle constants in Q30
    localparam longint PI_Q30          = 64'sd3373259426;
    localparam longint HALF_PI_Q30     = 64'sd1686629713;
    localparam longint TWO_PI_Q30      = 64'sd6746518852;
    localparam longint ANGLE_FLOOR_Q30 = -64'sd1855292684;
    localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;

    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh80000000;

    // cordic results toward the sequencer
    typedef struct packed {
        logic                  done;
        logic signed [Q_W-1:0] cos_val;
        logic signed [Q_W-1:0] sin_val;
    } cordic_res_t;

    // square root result toward the sequencer
    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] root;
    } sqrt_res_t;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [Q_W-1:0] r;
        if (v > 64'(Q_MAX))
            r = Q_MAX;
        else if (v < 64'(Q_MIN))
            r = Q_MIN;
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

    // arctangent table, Q30
    function automatic logic [31:0] atan_q30(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd843314857;
            5'd1:  r = 32'd497837829;
            5'd2:  r = 32'd263043836;
            5'd3:  r = 32'd133525158;
            5'd4:  r = 32'd67021686;
            5'd5:  r = 32'd33543515;
            5'd6:  r = 32'd16775850;
            5'd7:  r = 32'd8388437;
            5'd8:  r = 32'd4194282;
            5'd9:  r = 32'd2097149;
            5'd10: r = 32'd1048575;
            5'd11: r = 32'd524287;
            5'd12: r = 32'd262143;
            5'd13: r = 32'd131071;
            5'd14: r = 32'd65535;
            5'd15: r = 32'd32767;
            5'd16: r = 32'd16383;
            5'd17: r = 32'd8191;
            5'd18: r = 32'd4095;
            5'd19: r = 32'd2047;
            5'd20: r = 32'd1024;
            5'd21: r = 32'd512;
            5'd22: r = 32'd256;
            5'd23: r = 32'd128;
            5'd24: r = 32'd64;
            5'd25: r = 32'd32;
            5'd26: r = 32'd16;
            5'd27: r = 32'd8;
            5'd28: r = 32'd4;
            5'd29: r = 32'd2;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/bssi_if.sv */
// ----------------------------------------------------------------------------
// bssi channel interfaces
// valid/ready channels for step items and result items
// ----------------------------------------------------------------------------
interface bssi_in_if;
    import bssi_pkg::*;

    logic                  valid;
    logic                  ready;
    logic signed [Q_W-1:0] torque_guess;

    modport source (output valid, output torque_guess, input ready);
    modport sink   (input valid, input torque_guess, output ready);
endinterface

interface bssi_out_if;
    import bssi_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [Q_W-1:0]   pos_x;
    logic signed [Q_W-1:0]   pos_y;
    logic signed [Q_W-1:0]   angle_out;
    logic                    last_step;
    logic [ERR_W-1:0]        shot_error;
    logic                    radicand_clamped;

    modport source (output valid, output pos_x, output pos_y, output angle_out,
                    output last_step, output shot_error, output radicand_clamped,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input angle_out,
                    input last_step, input shot_error, input radicand_clamped,
                    output ready);
endinterface

/* rtl/bssi_cordic.sv */
// ----------------------------------------------------------------------------
// bssi_cordic
// iterative cosine/sine: range reduction, quadrant fold, 30 rotations
// ----------------------------------------------------------------------------
module bssi_cordic #(
    parameter int FRAC_BITS = bssi_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [bssi_pkg::Q_W-1:0] angle,
    output bssi_pkg::cordic_res_t       res
);
    import bssi_pkg::*;

    localparam int ZW   = 68 - FRAC_BITS;
    localparam int XW   = 34;
    localparam int KTOP = 31 - FRAC_BITS;
    localparam int SH   = 30 - FRAC_BITS;

    localparam logic signed [ZW-1:0] PI_Z      = ZW'(PI_Q30);
    localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(HALF_PI_Q30);
    localparam logic signed [ZW-1:0] TWO_PI_Z  = ZW'(TWO_PI_Q30);
    localparam logic signed [XW-1:0] GAIN_X    = XW'(CORDIC_GAIN_Q30);

    typedef enum logic [2:0] {C_IDLE, C_RED, C_FIX, C_FOLD, C_ITER} cstate_t;

    cstate_t              state_reg;
    logic signed [ZW-1:0] z_reg;
    logic signed [XW-1:0] x_reg;
    logic signed [XW-1:0] y_reg;
    logic                 neg_reg;
    logic [4:0]           cnt_reg;
    logic                 done_reg;

    logic signed [ZW-1:0] two_pi_k;
    logic signed [ZW-1:0] z_sub;
    logic signed [ZW-1:0] z_add;
    logic signed [XW-1:0] x_sh;
    logic signed [XW-1:0] y_sh;
    logic signed [ZW-1:0] atan_z;
    logic signed [XW-1:0] x_out;
    logic signed [XW-1:0] y_out;

    // shared shifter and adders of the unit
    always_comb
    begin
        two_pi_k = TWO_PI_Z <<< cnt_reg;
        z_sub    = z_reg - two_pi_k;
        z_add    = z_reg + two_pi_k;
        x_sh     = x_reg >>> cnt_reg;
        y_sh     = y_reg >>> cnt_reg;
        atan_z   = ZW'($signed({1'b0, atan_q30(cnt_reg)}));
        x_out    = x_reg >>> SH;
        y_out    = y_reg >>> SH;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                C_IDLE:
                begin
                    if (start)
                    begin
                        z_reg     <= ZW'(angle) <<< SH;
                        cnt_reg   <= 5'(KTOP);
                        state_reg <= C_RED;
                    end
                end
                C_RED:
                begin
                    // take away the largest multiples of two pi first
                    if (z_reg > PI_Z)
                    begin
                        if (z_sub > PI_Z)
                            z_reg <= z_sub;
                    end
                    else if (z_reg < -PI_Z)
                    begin
                        if (z_add < -PI_Z)
                            z_reg <= z_add;
                    end
                    if (cnt_reg == 5'd0)
                        state_reg <= C_FIX;
                    else
                        cnt_reg <= cnt_reg - 5'd1;
                end
                C_FIX:
                begin
                    if (z_reg > PI_Z)
                        z_reg <= z_reg - TWO_PI_Z;
                    else if (z_reg < -PI_Z)
                        z_reg <= z_reg + TWO_PI_Z;
                    state_reg <= C_FOLD;
                end
                C_FOLD:
                begin
                    // fold into the right half plane, negate at the end
                    if (z_reg > HALF_PI_Z)
                    begin
                        z_reg   <= z_reg - PI_Z;
                        neg_reg <= 1'b1;
                    end
                    else if (z_reg < -HALF_PI_Z)
                    begin
                        z_reg   <= z_reg + PI_Z;
                        neg_reg <= 1'b1;
                    end
                    else
                    begin
                        neg_reg <= 1'b0;
                    end
                    x_reg     <= GAIN_X;
                    y_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= C_ITER;
                end
                C_ITER:
                begin
                    if (z_reg >= 0)
                    begin
                        x_reg <= x_reg - y_sh;
                        y_reg <= y_reg + x_sh;
                        z_reg <= z_reg - atan_z;
                    end
                    else
                    begin
                        x_reg <= x_reg + y_sh;
                        y_reg <= y_reg - x_sh;
                        z_reg <= z_reg + atan_z;
                    end
                    if (cnt_reg == 5'(CORDIC_ITERS - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= C_IDLE;
                    end
                    else
                        cnt_reg <= cnt_reg + 5'd1;
                end
                default:
                    state_reg <= C_IDLE;
            endcase
        end
    end

    // results floored to the working format
    always_comb
    begin
        res.done    = done_reg;
        res.cos_val = neg_reg ? -x_out[Q_W-1:0] : x_out[Q_W-1:0];
        res.sin_val = neg_reg ? -y_out[Q_W-1:0] : y_out[Q_W-1:0];
    end

endmodule

/* rtl/bssi_isqrt.sv */
// ----------------------------------------------------------------------------
// bssi_isqrt
// bitwise integer square root of a 64-bit value, one result bit a cycle
// ----------------------------------------------------------------------------
module bssi_isqrt (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [63:0]          value,
    output bssi_pkg::sqrt_res_t  res
);
    import bssi_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] v_reg;
    logic [63:0] res_reg;

    logic [63:0] bit_val;
    logic [63:0] trial;

    // trial subtract of the current bit pair
    always_comb
    begin
        bit_val = 64'd1 << {cnt_reg, 1'b0};
        trial   = res_reg + bit_val;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (!busy_reg)
            begin
                if (start)
                begin
                    v_reg    <= value;
                    res_reg  <= '0;
                    cnt_reg  <= 5'd31;
                    busy_reg <= 1'b1;
                end
            end
            else
            begin
                if (v_reg >= trial)
                begin
                    v_reg   <= v_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_val;
                end
                else
                    res_reg <= res_reg >> 1;
                if (cnt_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                    cnt_reg <= cnt_reg - 5'd1;
            end
        end
    end

    assign res.done = done_reg;
    assign res.root = res_reg[Q_W-1:0];

endmodule

/* rtl/bending_strip_shot_integrator_unit.sv */
// ----------------------------------------------------------------------------
// bending_strip_shot_integrator_unit
// explicit Euler shooting trial of a bending strip, one integration step per item
// ----------------------------------------------------------------------------
// Usage: each item on in_chan is one integration step; torque_guess is read
// only on the first step of a shot. Every step returns one item on out_chan:
// the x, y and angle held before the step, last_step on the final step of a
// shot, shot_error on that final step (0 otherwise) and the sticky radicand
// clamp flag of the shot. After the final step the next item starts a new shot.
// Registers are written through cfg_we/cfg_index/cfg_wdata; the user must keep
// such writes to idle, as the block itself does not enforce it. Each step
// runs two CORDIC passes, each of range reduction, fold and 30 rotations, one
// square root, eight multiply steps of the single 36x33 multiplier (at
// FRAC_BITS = 24) and the accept, load, record and hand-off states; the
// final step of a shot adds the error computation. in_chan.ready is high
// only while the sequencer is idle.
// Reset clears the shot state and loads the register defaults; the block is
// ready on the first cycle after reset. A result waits in the output register
// while the receiver stalls; the next item is still accepted and computed, and
// its result is held back until the output register is free.
// ----------------------------------------------------------------------------
module bending_strip_shot_integrator_unit #(
    parameter int FRAC_BITS   = bssi_pkg::FRAC_BITS_DEF,
    parameter int INDEX_WIDTH = bssi_pkg::INDEX_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [bssi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bssi_pkg::Q_W-1:0]          cfg_wdata,
    bssi_in_if.sink                           in_chan,
    bssi_out_if.source                        out_chan
);
    import bssi_pkg::*;

`include "bending_strip_shot_integrator_unit_assert.svh"

    localparam int MA_W = (60 - FRAC_BITS > 36) ? (60 - FRAC_BITS) : 36;
    localparam int MB_W = 33;
    localparam logic signed [32:0] ONE33 = 33'sd1 <<< FRAC_BITS;
    localparam logic signed [Q_W-1:0] ANGLE_FLOOR =
        Q_W'(ANGLE_FLOOR_Q30 >>> (30 - FRAC_BITS));
    localparam logic signed [63:0] RAD_MAX = (64'sd1 <<< (63 - FRAC_BITS)) - 64'sd1;
    localparam logic [PEN_W+1:0] PEN_MAX = {2'b00, {PEN_W{1'b1}}};
    localparam logic signed [63:0] ERR_MAX = 64'sd2147483647;

    typedef enum logic [4:0] {
        S_IDLE, S_INIT, S_REC, S_COS1, S_M1, S_M2, S_M3, S_M4, S_SQ,
        S_M5, S_M6, S_COS2, S_M7, S_M8, S_M9, S_M10, S_ERR, S_DONE
    } state_t;

    state_t state_reg;

    // configuration registers
    logic signed [Q_W-1:0] coef_m_reg;
    logic signed [Q_W-1:0] coef_n_reg;
    logic signed [Q_W-1:0] inv_two_m_reg;
    logic signed [Q_W-1:0] start_angle_reg;
    logic [H_W-1:0]        h_reg;
    logic [STEPS_W-1:0]    steps_reg;

    // shot state
    logic [INDEX_WIDTH-1:0] idx_reg;
    logic signed [Q_W-1:0]  x_reg;
    logic signed [Q_W-1:0]  y_reg;
    logic signed [Q_W-1:0]  ang_reg;
    logic signed [Q_W-1:0]  prev_reg;
    logic signed [Q_W-1:0]  mom_reg;
    logic signed [Q_W-1:0]  arc_reg;
    logic signed [XSUM_W-1:0] xsum_reg;
    logic [PEN_W-1:0]       pen_reg;
    logic                   clamp_reg;
    logic signed [Q_W-1:0]  torque_reg;

    // per-step working registers
    logic signed [Q_W-1:0]  in_t_reg;
    logic signed [63:0]     tmp_reg;
    logic signed [Q_W-1:0]  mnew_reg;
    logic signed [Q_W-1:0]  c_reg;
    logic signed [Q_W-1:0]  s_reg;
    logic signed [Q_W-1:0]  rec_x_reg;
    logic signed [Q_W-1:0]  rec_y_reg;
    logic signed [Q_W-1:0]  rec_a_reg;
    logic                   last_reg;
    logic [ERR_W-1:0]       err_reg;

    // output register
    logic                   out_valid_reg;
    logic signed [Q_W-1:0]  out_x_reg;
    logic signed [Q_W-1:0]  out_y_reg;
    logic signed [Q_W-1:0]  out_a_reg;
    logic                   out_last_reg;
    logic [ERR_W-1:0]       out_err_reg;
    logic                   out_clamp_reg;

    // shared units
    logic                   cs_start;
    logic signed [Q_W-1:0]  cs_angle;
    cordic_res_t            cs_res;
    logic                   sq_start;
    logic [63:0]            sq_value;
    sqrt_res_t              sq_res;

    // combinational helpers
    logic signed [MA_W-1:0] mul_a;
    logic signed [MB_W-1:0] mul_b;
    logic signed [63:0]     prod;
    logic signed [63:0]     psh;
    logic signed [63:0]     rad;
    logic signed [63:0]     radv;
    logic                   rad_neg;
    logic signed [Q_W-1:0]  a_new;
    logic [INDEX_WIDTH-1:0] nsteps;
    logic                   last_now;
    logic [PEN_W+1:0]       pen_sum;
    logic [PEN_W-1:0]       pen_new;
    logic signed [63:0]     err_diff;
    logic signed [63:0]     err_abs;
    logic signed [63:0]     err_tot;
    logic                   out_free;
    logic signed [MB_W-1:0] h_op;

    bssi_cordic #(.FRAC_BITS(FRAC_BITS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cs_start),
        .angle (cs_angle),
        .res   (cs_res)
    );

    bssi_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (sq_value),
        .res   (sq_res)
    );

    // multiplier operand select and product
    always_comb
    begin
        h_op  = MB_W'($signed({1'b0, h_reg}));
        mul_a = '0;
        mul_b = h_op;
        case (state_reg)
            S_M1: mul_a = MA_W'($signed({arc_reg[Q_W-1], arc_reg}) - ONE33);
            S_M2:
            begin
                mul_a = MA_W'(tmp_reg);
                mul_b = MB_W'(c_reg);
            end
            S_M3:
            begin
                mul_a = MA_W'(coef_n_reg);
                mul_b = MB_W'(coef_n_reg);
            end
            S_M4:
            begin
                mul_a = MA_W'(mnew_reg);
                mul_b = MB_W'(coef_m_reg);
            end
            S_M5:
            begin
                mul_a = MA_W'(tmp_reg);
                mul_b = MB_W'(inv_two_m_reg);
            end
            S_M6:  mul_a = MA_W'(tmp_reg);
            S_M7:  mul_a = MA_W'(c_reg);
            S_M8:  mul_a = MA_W'(s_reg);
            S_M9:  mul_a = MA_W'(xsum_reg >>> FRAC_BITS);
            S_M10: mul_a = MA_W'($signed({1'b0, xsum_reg[FRAC_BITS-1:0]}));
            default: mul_a = '0;
        endcase
        prod = 64'(mul_a * mul_b);
        psh  = prod >>> FRAC_BITS;
    end

    // radicand, new angle, step count, penalty and error
    always_comb
    begin
        rad     = tmp_reg + (psh <<< 2);
        rad_neg = rad < 0;
        if (rad_neg)
            radv = '0;
        else if (rad > RAD_MAX)
            radv = RAD_MAX;
        else
            radv = rad;
        sq_value = 64'(radv) << FRAC_BITS;
        a_new    = sat32(64'(ang_reg) - psh);

        nsteps = INDEX_WIDTH'(steps_reg);
        if (nsteps < INDEX_WIDTH'(2))
            nsteps = INDEX_WIDTH'(2);
        last_now = idx_reg >= (nsteps - INDEX_WIDTH'(1));

        pen_sum = (PEN_W + 2)'(pen_reg);
        if (ang_reg > 0)
            pen_sum = pen_sum + (PEN_W + 2)'(ang_reg);
        else if (ang_reg < ANGLE_FLOOR)
            pen_sum = pen_sum + (PEN_W + 2)'(33'(ANGLE_FLOOR) - 33'(ang_reg));
        if (idx_reg != '0 && ang_reg > prev_reg)
            pen_sum = pen_sum + (PEN_W + 2)'(33'(ang_reg) - 33'(prev_reg));
        pen_new = (pen_sum > PEN_MAX) ? PEN_MAX[PEN_W-1:0] : pen_sum[PEN_W-1:0];

        err_diff = tmp_reg - 64'(torque_reg);
        err_abs  = (err_diff < 0) ? -err_diff : err_diff;
        err_tot  = err_abs + 64'($signed({1'b0, pen_reg}));

        cs_start = (state_reg == S_REC) || (state_reg == S_M6);
        cs_angle = (state_reg == S_M6) ? a_new : ang_reg;
        sq_start = (state_reg == S_M4);
        out_free = !out_valid_reg || out_chan.ready;
    end

    // sequencer, configuration and shot state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            coef_m_reg      <= COEF_M_RST;
            coef_n_reg      <= COEF_N_RST;
            inv_two_m_reg   <= INV_TWO_M_RST;
            start_angle_reg <= START_ANGLE_RST;
            h_reg           <= STEP_LENGTH_RST;
            steps_reg       <= STEPS_RST;
            idx_reg         <= '0;
            x_reg           <= '0;
            y_reg           <= '0;
            ang_reg         <= '0;
            prev_reg        <= '0;
            mom_reg         <= '0;
            arc_reg         <= '0;
            xsum_reg        <= '0;
            pen_reg         <= '0;
            clamp_reg       <= 1'b0;
            torque_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_COEF_M:      coef_m_reg      <= cfg_wdata;
                    REG_COEF_N:      coef_n_reg      <= cfg_wdata;
                    REG_INV_TWO_M:   inv_two_m_reg   <= cfg_wdata;
                    REG_START_ANGLE: start_angle_reg <= cfg_wdata;
                    REG_STEP_LENGTH: h_reg           <= cfg_wdata[H_W-1:0];
                    REG_STEPS:       steps_reg       <= cfg_wdata[STEPS_W-1:0];
                    default:         ;
                endcase
            end

            // output register drains unless a new item is loaded below
            if (out_valid_reg && out_chan.ready && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_chan.valid)
                    begin
                        in_t_reg  <= in_chan.torque_guess;
                        state_reg <= S_INIT;
                    end
                end
                S_INIT:
                begin
                    // first step of a shot loads the start conditions
                    if (idx_reg == '0)
                    begin
                        torque_reg <= in_t_reg;
                        mom_reg    <= in_t_reg;
                        ang_reg    <= start_angle_reg;
                        x_reg      <= '0;
                        y_reg      <= '0;
                        arc_reg    <= '0;
                        xsum_reg   <= '0;
                        pen_reg    <= '0;
                        prev_reg   <= '0;
                        clamp_reg  <= 1'b0;
                    end
                    state_reg <= S_REC;
                end
                S_REC:
                begin
                    rec_x_reg <= x_reg;
                    rec_y_reg <= y_reg;
                    rec_a_reg <= ang_reg;
                    xsum_reg  <= xsum_reg + XSUM_W'(x_reg);
                    pen_reg   <= pen_new;
                    prev_reg  <= ang_reg;
                    last_reg  <= last_now;
                    state_reg <= S_COS1;
                end
                S_COS1:
                begin
                    if (cs_res.done)
                    begin
                        c_reg     <= cs_res.cos_val;
                        state_reg <= S_M1;
                    end
                end
                S_M1:
                begin
                    tmp_reg   <= psh;
                    state_reg <= S_M2;
                end
                S_M2:
                begin
                    mnew_reg  <= sat32(64'(mom_reg) + psh);
                    state_reg <= S_M3;
                end
                S_M3:
                begin
                    tmp_reg   <= psh;
                    state_reg <= S_M4;
                end
                S_M4:
                begin
                    if (rad_neg)
                        clamp_reg <= 1'b1;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    if (sq_res.done)
                    begin
                        tmp_reg   <= 64'(sat32(64'(coef_n_reg)
                                     + 64'($signed({1'b0, sq_res.root}))));
                        state_reg <= S_M5;
                    end
                end
                S_M5:
                begin
                    tmp_reg   <= 64'(sat32(psh));
                    state_reg <= S_M6;
                end
                S_M6:
                begin
                    ang_reg   <= a_new;
                    mom_reg   <= mnew_reg;
                    arc_reg   <= sat32(64'(arc_reg) + 64'($signed({1'b0, h_reg})));
                    state_reg <= S_COS2;
                end
                S_COS2:
                begin
                    if (cs_res.done)
                    begin
                        c_reg     <= cs_res.cos_val;
                        s_reg     <= cs_res.sin_val;
                        state_reg <= S_M7;
                    end
                end
                S_M7:
                begin
                    x_reg     <= sat32(64'(x_reg) + psh);
                    state_reg <= S_M8;
                end
                S_M8:
                begin
                    y_reg   <= sat32(64'(y_reg) + psh);
                    err_reg <= '0;
                    if (last_reg)
                        state_reg <= S_M9;
                    else
                        state_reg <= S_DONE;
                end
                S_M9:
                begin
                    tmp_reg   <= prod;
                    state_reg <= S_M10;
                end
                S_M10:
                begin
                    tmp_reg   <= tmp_reg + psh;
                    state_reg <= S_ERR;
                end
                S_ERR:
                begin
                    err_reg   <= (err_tot > ERR_MAX) ? ERR_W'(ERR_MAX) : err_tot[ERR_W-1:0];
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    // hand the item to the output register once it is free
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= rec_x_reg;
                        out_y_reg     <= rec_y_reg;
                        out_a_reg     <= rec_a_reg;
                        out_last_reg  <= last_reg;
                        out_err_reg   <= err_reg;
                        out_clamp_reg <= clamp_reg;
                        idx_reg       <= last_reg ? '0 : idx_reg + INDEX_WIDTH'(1);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // channel ports
    assign in_chan.ready              = (state_reg == S_IDLE);
    assign out_chan.valid             = out_valid_reg;
    assign out_chan.pos_x             = out_x_reg;
    assign out_chan.pos_y             = out_y_reg;
    assign out_chan.angle_out         = out_a_reg;
    assign out_chan.last_step         = out_last_reg;
    assign out_chan.shot_error        = out_err_reg;
    assign out_chan.radicand_clamped  = out_clamp_reg;

    // checks
    `BSSI_ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
        in_chan.valid && in_chan.ready, !in_chan.ready)
    `BSSI_ASSERT_SAME(a_error_only_on_last, clk, rst_n,
        out_valid_reg && !out_last_reg, out_err_reg == '0)
    `BSSI_ASSERT_NEXT(a_index_wraps_after_last, clk, rst_n,
        (state_reg == S_DONE) && out_free && last_reg, idx_reg == '0)

endmodule
